@@ rtl/bdd_pkg.sv @@
// ============================================================================
// bdd_pkg
// Shared types and constants for the box delta decoder.
// ============================================================================
`default_nettype none

package bdd_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int DLIM      = 10 << FRAC_BITS;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [15:0] EXP_A     = 16'd43024;
    localparam logic [14:0] EXP_B     = 15'd22512;

    localparam logic [15:0] SCALE_RESET = 16'(ONE);

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_CY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_CX = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_H  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_W  = 8'd3;

    typedef struct packed {
        logic signed [15:0] anchor_ymin;
        logic signed [15:0] anchor_xmin;
        logic signed [15:0] anchor_ymax;
        logic signed [15:0] anchor_xmax;
        logic signed [15:0] delta_cy;
        logic signed [15:0] delta_cx;
        logic signed [15:0] delta_h;
        logic signed [15:0] delta_w;
    } in_t;

    typedef struct packed {
        logic [12:0] out_ymin;
        logic [12:0] out_xmin;
        logic [12:0] out_ymax;
        logic [12:0] out_xmax;
    } out_t;

endpackage

`default_nettype wire

@@ rtl/bdd_axis.sv @@
// ============================================================================
// bdd_axis
// Seven-stage decode pipeline for one axis (corner pair, centre and size).
// ============================================================================
`default_nettype none

module bdd_axis (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [15:0] lo,
    input  wire logic signed [15:0] hi,
    input  wire logic signed [15:0] dc_raw,
    input  wire logic signed [15:0] ds_raw,
    input  wire logic        [15:0] sc,
    input  wire logic        [15:0] ss,
    output logic             [12:0] lo_out,
    output logic             [12:0] hi_out
);
    import bdd_pkg::*;

    // stage 1
    logic signed [32:0] dc_p, ds_p, dc_sh, ds_sh;
    logic signed [16:0] dc_next, ds_next;
    logic signed [16:0] s1_dc_reg, s1_ds_reg, s1_size_reg, s1_c2_reg;
    // stage 2
    logic signed [33:0] s2_dcs_reg;
    logic signed [48:0] s2_yp_reg;
    logic signed [16:0] s2_size_reg, s2_c2_reg;
    // stage 3
    logic signed [16:0] y;
    logic        [11:0] f;
    logic        [27:0] s3_p1_reg;
    logic        [23:0] s3_ff_reg;
    logic signed [4:0]  s3_n_reg;
    logic signed [16:0] s3_size_reg;
    logic signed [23:0] s3_nc2_reg;
    // stage 4
    logic        [28:0] msum;
    logic        [12:0] s4_m_reg;
    logic signed [4:0]  s4_n_reg;
    logic signed [16:0] s4_size_reg;
    logic signed [23:0] s4_nc2_reg;
    // stage 5
    logic        [26:0] e_next;
    logic        [26:0] s5_e_reg;
    logic signed [16:0] s5_size_reg;
    logic signed [23:0] s5_nc2_reg;
    // stage 6
    logic signed [44:0] nsz_p;
    logic signed [32:0] s6_nsz_reg;
    logic signed [23:0] s6_nc2_reg;
    // stage 7
    logic signed [34:0] a_sum, b_sum, a_sh, b_sh;
    logic        [12:0] a_cl, b_cl;
    logic        [12:0] lo_reg, hi_reg;

    function automatic logic [12:0] clamp01(input logic signed [34:0] v);
        logic [12:0] r;
        if (v < 0)
            r = '0;
        else if (v > 35'(ONE))
            r = 13'(ONE);
        else
            r = v[12:0];
        return r;
    endfunction

    always_comb
    begin
        dc_p  = dc_raw * $signed({17'd0, sc});
        ds_p  = ds_raw * $signed({17'd0, ss});
        dc_sh = dc_p >>> FRAC_BITS;
        ds_sh = ds_p >>> FRAC_BITS;
        if (dc_sh < -33'(DLIM))
            dc_next = -17'(DLIM);
        else if (dc_sh > 33'(DLIM))
            dc_next = 17'(DLIM);
        else
            dc_next = dc_sh[16:0];
        if (ds_sh < -33'(DLIM))
            ds_next = -17'(DLIM);
        else if (ds_sh > 33'(DLIM))
            ds_next = 17'(DLIM);
        else
            ds_next = ds_sh[16:0];

        y = s2_yp_reg[46:30];
        f = y[11:0];

        msum = 29'(s3_p1_reg) + 29'(s3_ff_reg[23:12] * EXP_B);

        if (s4_n_reg >= 0)
            e_next = 27'(s4_m_reg) << s4_n_reg[3:0];
        else
            e_next = 27'(s4_m_reg) >> 5'(-s4_n_reg);

        nsz_p = s5_size_reg * $signed({1'b0, s5_e_reg});

        a_sum = 35'(s6_nc2_reg) - 35'(s6_nsz_reg);
        b_sum = 35'(s6_nc2_reg) + 35'(s6_nsz_reg);
        a_sh  = a_sum >>> 1;
        b_sh  = b_sum >>> 1;
        a_cl  = clamp01(a_sh);
        b_cl  = clamp01(b_sh);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dc_reg   <= dc_next;
            s1_ds_reg   <= ds_next;
            s1_size_reg <= 17'(hi) - 17'(lo);
            s1_c2_reg   <= 17'(hi) + 17'(lo);

            s2_dcs_reg  <= s1_dc_reg * s1_size_reg;
            s2_yp_reg   <= s1_ds_reg * $signed({1'b0, LOG2E_Q30});
            s2_size_reg <= s1_size_reg;
            s2_c2_reg   <= s1_c2_reg;

            s3_p1_reg   <= f * EXP_A;
            s3_ff_reg   <= f * f;
            s3_n_reg    <= y[16:12];
            s3_size_reg <= s2_size_reg;
            s3_nc2_reg  <= 24'(s2_c2_reg) + 24'($signed({s2_dcs_reg[33:12], 1'b0}));

            s4_m_reg    <= 13'(ONE) + 13'(msum[28:16]);
            s4_n_reg    <= s3_n_reg;
            s4_size_reg <= s3_size_reg;
            s4_nc2_reg  <= s3_nc2_reg;

            s5_e_reg    <= e_next;
            s5_size_reg <= s4_size_reg;
            s5_nc2_reg  <= s4_nc2_reg;

            s6_nsz_reg  <= nsz_p[44:12];
            s6_nc2_reg  <= s5_nc2_reg;

            lo_reg      <= a_cl;
            hi_reg      <= (a_cl > b_cl) ? a_cl : b_cl;
        end
    end

    assign lo_out = lo_reg;
    assign hi_out = hi_reg;

endmodule

`default_nettype wire

@@ rtl/box_delta_decode_unit.sv @@
// Throughput: one box per cycle; the seven-stage datapath advances whenever
// the output register is empty or being taken.
// Reset: valid bits cleared, scale registers return to 1.0 (4096).
// ============================================================================
// box_delta_decode_unit
// Bounding-box regression decoder, anchor plus deltas to clamped corners.
// ============================================================================
`default_nettype none

module box_delta_decode_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire bdd_pkg::in_t                  in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output bdd_pkg::out_t                      out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import bdd_pkg::*;

    localparam int DEPTH = 7;

    logic [15:0]      scale_cy_reg, scale_cx_reg, scale_h_reg, scale_w_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             en;

    assign en        = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[DEPTH-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            scale_cy_reg <= SCALE_RESET;
            scale_cx_reg <= SCALE_RESET;
            scale_h_reg  <= SCALE_RESET;
            scale_w_reg  <= SCALE_RESET;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SCALE_CY: scale_cy_reg <= cfg_data;
                    REG_SCALE_CX: scale_cx_reg <= cfg_data;
                    REG_SCALE_H:  scale_h_reg  <= cfg_data;
                    REG_SCALE_W:  scale_w_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    bdd_axis u_axis_y (
        .clk    (clk),
        .en     (en),
        .lo     (in_data.anchor_ymin),
        .hi     (in_data.anchor_ymax),
        .dc_raw (in_data.delta_cy),
        .ds_raw (in_data.delta_h),
        .sc     (scale_cy_reg),
        .ss     (scale_h_reg),
        .lo_out (out_data.out_ymin),
        .hi_out (out_data.out_ymax)
    );

    bdd_axis u_axis_x (
        .clk    (clk),
        .en     (en),
        .lo     (in_data.anchor_xmin),
        .hi     (in_data.anchor_xmax),
        .dc_raw (in_data.delta_cx),
        .ds_raw (in_data.delta_w),
        .sc     (scale_cx_reg),
        .ss     (scale_w_reg),
        .lo_out (out_data.out_xmin),
        .hi_out (out_data.out_xmax)
    );

`ifndef SYNTH
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall not tied to output back-pressure");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.out_ymax >= out_data.out_ymin &&
                       out_data.out_xmax >= out_data.out_xmin))
        else $error("max corner below min corner");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.out_ymax <= 13'(ONE) && out_data.out_xmax <= 13'(ONE)))
        else $error("corner beyond 1.0");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_stall && !in_valid && !vld_reg[DEPTH-2]) |=> !out_valid)
        else $error("output beat without source");
`endif

endmodule

`default_nettype wire

@@ test/bdd_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bdd_checker
// Watches the box and result channels of the box delta decoder, computes the
// decoded box for every accepted anchor beat and compares each result beat
// against the oldest pending box, field by field.
// ============================================================================
`default_nettype none

module bdd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire bdd_pkg::in_t                  in_data,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire bdd_pkg::out_t                 out_data,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [bdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data,
    output int                                 errors,
    output int                                 pending
);
    import bdd_pkg::*;

    logic [15:0] sc_cy, sc_cx, sc_h, sc_w;
    out_t        boxes_due[$];

    assign pending = boxes_due.size();

    function automatic longint fdiv(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint scale_delta(logic signed [15:0] raw, logic [15:0] sc);
        longint d;
        d = fdiv(longint'(raw) * longint'({1'b0, sc}), FRAC_BITS);
        return clampl(d, -DLIM, DLIM);
    endfunction

    function automatic longint exp_q(longint x);
        longint y, n, f, m;
        y = fdiv(x * 64'sd1549082005, 30);
        n = fdiv(y, FRAC_BITS);
        f = y - n * ONE;
        m = ONE + fdiv(f * 43024 + fdiv(f * f, FRAC_BITS) * 22512, 16);
        if (n >= 0)
            return m << n;
        return m >> (-n);
    endfunction

    function automatic void axis_decode(logic signed [15:0] lo_r, logic signed [15:0] hi_r,
                                        longint dc, longint ds,
                                        output logic [12:0] lo_o, output logic [12:0] hi_o);
        longint sz, c2, nc2, nsz, a, b;
        sz  = longint'(hi_r) - longint'(lo_r);
        c2  = longint'(hi_r) + longint'(lo_r);
        nc2 = c2 + 2 * fdiv(dc * sz, FRAC_BITS);
        nsz = fdiv(sz * exp_q(ds), FRAC_BITS);
        a   = clampl(fdiv(nc2 - nsz, 1), 0, ONE);
        b   = clampl(fdiv(nc2 + nsz, 1), 0, ONE);
        if (a > b)
            b = a;
        lo_o = a[12:0];
        hi_o = b[12:0];
    endfunction

    function automatic out_t decode_box(in_t b);
        out_t r;
        axis_decode(b.anchor_ymin, b.anchor_ymax, scale_delta(b.delta_cy, sc_cy),
                    scale_delta(b.delta_h, sc_h), r.out_ymin, r.out_ymax);
        axis_decode(b.anchor_xmin, b.anchor_xmax, scale_delta(b.delta_cx, sc_cx),
                    scale_delta(b.delta_w, sc_w), r.out_xmin, r.out_xmax);
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_cy <= SCALE_RESET;
            sc_cx <= SCALE_RESET;
            sc_h  <= SCALE_RESET;
            sc_w  <= SCALE_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCALE_CY: sc_cy <= cfg_data;
                    REG_SCALE_CX: sc_cx <= cfg_data;
                    REG_SCALE_H:  sc_h  <= cfg_data;
                    REG_SCALE_W:  sc_w  <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                boxes_due.push_back(decode_box(in_data));
            if (out_valid && !out_stall)
            begin
                out_t want;
                if (boxes_due.size() == 0)
                begin
                    $display("unexpected result beat at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    want = boxes_due.pop_front();
                    if (out_data.out_ymin !== want.out_ymin)
                        report("out_ymin", out_data.out_ymin, want.out_ymin);
                    if (out_data.out_xmin !== want.out_xmin)
                        report("out_xmin", out_data.out_xmin, want.out_xmin);
                    if (out_data.out_ymax !== want.out_ymax)
                        report("out_ymax", out_data.out_ymax, want.out_ymax);
                    if (out_data.out_xmax !== want.out_xmax)
                        report("out_xmax", out_data.out_xmax, want.out_xmax);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Box delta decoder test: directed corner boxes, then random anchors and
// deltas under several scale settings, with bursty input and random output
// stalls. Results are checked by bdd_checker.
// ============================================================================
`default_nettype none

module tb;
    import bdd_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_t                  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_t                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    int                   errors;
    int                   pending;
    int                   cycles = 0;
    int                   stall_mode = 0;

    always #5 clk = ~clk;

    box_delta_decode_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bdd_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // receiver stall pattern, mode changes per phase
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= cycles[3];
        endcase
        if (cycles > 400000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_box(in_t b);
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    function automatic logic signed [15:0] coord();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom);
            1:       return 16'sd4096 + 16'($urandom_range(0, 200)) - 16'sd100;
            default: return 16'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic logic signed [15:0] delta();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return 16'sd0;
            default: return 16'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic in_t rand_box();
        in_t b;
        b.anchor_ymin = coord();
        b.anchor_xmin = coord();
        b.anchor_ymax = coord();
        b.anchor_xmax = coord();
        b.delta_cy = delta();
        b.delta_cx = delta();
        b.delta_h  = delta();
        b.delta_w  = delta();
        if ($urandom_range(0, 3) != 0)
        begin
            if (b.anchor_ymax < b.anchor_ymin)
                {b.anchor_ymin, b.anchor_ymax} = {b.anchor_ymax, b.anchor_ymin};
            if (b.anchor_xmax < b.anchor_xmin)
                {b.anchor_xmin, b.anchor_xmax} = {b.anchor_xmax, b.anchor_xmin};
        end
        return b;
    endfunction

    task automatic random_phase(int n);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n > 0)
            begin
                send_box(rand_box());
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap();
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] sets[5][4];
        sets = '{'{16'd4096, 16'd4096, 16'd4096, 16'd4096},
                 '{16'd0, 16'd0, 16'd0, 16'd0},
                 '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                 '{16'd410, 16'd409, 16'd819, 16'd819},
                 '{16'd2048, 16'd8192, 16'd1, 16'd30000}};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, empty and inverted anchors, clamps
        send_box('0);
        send_box('{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                   16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
        send_box('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                   16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
        send_box('{16'sd1024, 16'sd1024, 16'sd1024, 16'sd1024,
                   16'sd4096, 16'sd0, 16'sd4096, 16'sd0});
        send_box('{16'sd3000, 16'sd3000, 16'sd1000, 16'sd1000,
                   16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_box('{16'sd0, 16'sd0, 16'sd4096, 16'sd4096,
                   16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_box('{16'sd1000, 16'sd1000, 16'sd3000, 16'sd3000,
                   16'sd4096, -16'sd4096, 16'sd8192, -16'sd8192});
        send_box('{16'sd2000, 16'sd2000, 16'sd2100, 16'sd2100,
                   16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000});
        send_box('{-16'sd4096, 16'sd4096, 16'sd8192, 16'sd8192,
                   -16'sd1, 16'sd1, -16'sd1, 16'sd1});
        send_box('1);
        idle_gap();
        drain();

        write_reg(8'd7, 16'd0);
        for (int p = 0; p < 5; p++)
        begin
            stall_mode = p % 4;
            write_reg(REG_SCALE_CY, sets[p][0]);
            write_reg(REG_SCALE_CX, sets[p][1]);
            write_reg(REG_SCALE_H,  sets[p][2]);
            write_reg(REG_SCALE_W,  sets[p][3]);
            random_phase(70);
            drain();
            stall_mode = (p + 1) % 4;
            random_phase(70);
            drain();
        end
        stall_mode = 1;
        random_phase(40);

        drain();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/bdd_pkg.sv
rtl/bdd_axis.sv
rtl/box_delta_decode_unit.sv
test/bdd_checker.sv
test/tb.sv
